// ----- hw/rtl/range_key_sorted_half_split_assert.svh -----
// assertion macros for the sorted half split block
`ifndef RANGE_KEY_SORTED_HALF_SPLIT_ASSERT_SVH
`define RANGE_KEY_SORTED_HALF_SPLIT_ASSERT_SVH

`define RKS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/rks_pkg.sv -----
`timescale 1ns / 1ps
package rks_pkg;
	localparam int MAX_ENTRIES = 64;
	localparam int KEY_WIDTH = 64;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] lower;
		logic [KEY_WIDTH-1:0] upper;
		logic                 close;
	} beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT
	} back_state_t;

	function automatic logic key_after(input logic [KEY_WIDTH-1:0] xl,
		input logic [KEY_WIDTH-1:0] xu, input logic [KEY_WIDTH-1:0] yl,
		input logic [KEY_WIDTH-1:0] yu);
		logic r;
		if (xl != yl) r = $signed(yl) < $signed(xl);
		else r = $signed(yu) < $signed(xu);
		return r;
	endfunction
endpackage

// ----- hw/rtl/rks_front.sv -----
`timescale 1ns / 1ps
// input register and small queue of beats toward the sorter
module rks_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     entry_lower,
	input  logic [63:0]     entry_upper,
	input  logic            last_entry,
	output logic            full,
	output logic            q_valid,
	output rks_pkg::beat_t  q_beat,
	input  logic            q_pop
);
	import rks_pkg::*;

	beat_t     buf_q [QDEPTH];
	logic [1:0] cnt_q;
	logic      push;

	assign full = (cnt_q == 2'(QDEPTH));
	assign push = start & ~full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_beat = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
	end

	always_ff @(posedge clk) begin
		if (q_pop) buf_q[0] <= buf_q[1];
		if (push) begin
			if (q_pop ? cnt_q == 2'd1 : cnt_q == 2'd0) begin
				buf_q[0] <= '{lower: entry_lower[KEY_WIDTH-1:0],
					upper: entry_upper[KEY_WIDTH-1:0], close: last_entry};
			end else begin
				buf_q[1] <= '{lower: entry_lower[KEY_WIDTH-1:0],
					upper: entry_upper[KEY_WIDTH-1:0], close: last_entry};
			end
		end
	end
endmodule

// ----- hw/rtl/rks_back.sv -----
`timescale 1ns / 1ps
// insertion chain of cells kept sorted on arrival, then an emit pass
module rks_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rks_pkg::beat_t q_beat,
	output logic           q_pop,
	output logic           emitting,
	output logic           done,
	output logic [6:0]     entry_position,
	output logic           goes_right,
	output logic [63:0]    left_lower,
	output logic [63:0]    left_upper,
	output logic [63:0]    right_lower,
	output logic [63:0]    right_upper,
	output logic [5:0]     left_count,
	output logic [6:0]     right_count,
	output logic           overflowed,
	output logic           last_result
);
	import rks_pkg::*;

	logic [KEY_WIDTH-1:0] lo_q  [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0] hi_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]     pos_q [MAX_ENTRIES];
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     k_q;
	logic                 ovf_q;
	back_state_t          st_q, st_d;
	logic [MAX_ENTRIES-1:0] after;
	logic [KEY_WIDTH-1:0] ll_q, lu_q, rl_q, ru_q;
	logic                 load, room;
	logic [CNT_W-1:0]     half;
	logic                 right_k, first_k, last_k;
	logic [KEY_WIDTH-1:0] ll_n, lu_n, rl_n, ru_n;
	logic signed [63:0]   lln, lun, rln, run;

	assign room = n_q < CNT_W'(MAX_ENTRIES);
	assign half = n_q >> 1;

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		case (st_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_beat.close) st_d = ST_EMIT;
			end
			ST_EMIT: if (k_q + 1'b1 == n_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end
	assign load = q_pop & room;
	assign emitting = (st_q == ST_EMIT);
	assign done = emitting & (k_q + 1'b1 == n_q);

	// cell i holds a later key when the new one sorts strictly before it
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++)
			after[i] = (CNT_W'(i) < n_q) &&
				key_after(lo_q[i], hi_q[i], q_beat.lower, q_beat.upper);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (after[i]) begin
					if (i > 0 && !after[i-1]) begin
						lo_q[i] <= q_beat.lower;
						hi_q[i] <= q_beat.upper;
						pos_q[i] <= n_q[IDX_W-1:0];
					end else if (i > 0) begin
						lo_q[i] <= lo_q[i-1];
						hi_q[i] <= hi_q[i-1];
						pos_q[i] <= pos_q[i-1];
					end else begin
						lo_q[i] <= q_beat.lower;
						hi_q[i] <= q_beat.upper;
						pos_q[i] <= n_q[IDX_W-1:0];
					end
				end else if (CNT_W'(i) == n_q) begin
					if (i > 0 && after[i-1]) begin
						lo_q[i] <= lo_q[i-1];
						hi_q[i] <= hi_q[i-1];
						pos_q[i] <= pos_q[i-1];
					end else begin
						lo_q[i] <= q_beat.lower;
						hi_q[i] <= q_beat.upper;
						pos_q[i] <= n_q[IDX_W-1:0];
					end
				end
			end
		end else if (emitting) begin
			// emit pass shifts the chain toward cell 0, one cell a cycle
			for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
				lo_q[i] <= lo_q[i+1];
				hi_q[i] <= hi_q[i+1];
				pos_q[i] <= pos_q[i+1];
			end
		end
	end

	// k_q counts the emitted cells; cell 0 always holds the current one
	assign right_k = k_q >= half;
	assign first_k = (k_q == '0) || (k_q == half);
	assign last_k = (k_q + 1'b1 == n_q);

	always_comb begin
		ll_n = ll_q; lu_n = lu_q; rl_n = rl_q; ru_n = ru_q;
		if (!right_k) begin
			if (first_k || $signed(lo_q[0]) < $signed(ll_q))
				ll_n = lo_q[0];
			if (first_k || $signed(lu_q) < $signed(hi_q[0]))
				lu_n = hi_q[0];
		end else begin
			if (k_q == half || $signed(lo_q[0]) < $signed(rl_q))
				rl_n = lo_q[0];
			if (k_q == half || $signed(ru_q) < $signed(hi_q[0]))
				ru_n = hi_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			n_q <= '0;
			k_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load) n_q <= n_q + 1'b1;
			if (q_pop && !room) ovf_q <= 1'b1;
			if (emitting) begin
				k_q <= k_q + 1'b1;
				if (done) begin
					k_q <= '0;
					n_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emitting) begin
			ll_q <= ll_n; lu_q <= lu_n; rl_q <= rl_n; ru_q <= ru_n;
		end
	end

	assign lln = 64'($signed(ll_n));
	assign lun = 64'($signed(lu_n));
	assign rln = 64'($signed(rl_n));
	assign run = 64'($signed(ru_n));

	always_comb begin
		entry_position = 7'(pos_q[0]) + 7'd1;
		goes_right = right_k;
		left_lower = '0; left_upper = '0; right_lower = '0; right_upper = '0;
		left_count = '0; right_count = '0; overflowed = 1'b0; last_result = 1'b0;
		if (last_k) begin
			if (half != '0) begin
				left_lower = lln;
				left_upper = lun;
			end
			right_lower = rln;
			right_upper = run;
			left_count = 6'(half);
			right_count = 7'(n_q - half);
			overflowed = ovf_q;
			last_result = 1'b1;
		end
	end
endmodule

// ----- hw/rtl/range_key_sorted_half_split.sv -----
`timescale 1ns / 1ps
// sorted half split of signed range keys
// input: raise start with entry_lower, entry_upper and last_entry; a beat is
// taken at a clock edge where start is high and busy is low. each accepted
// beat, up to 64 entries, is inserted into a sorted chain of cells, one beat per
// cycle while not emitting. last_entry closes the set.
// after the close the block emits n results on consecutive cycles, each
// marked by result_valid for one cycle, in sorted order (lower, then upper,
// then arrival). the final one carries last_result, group unions and counts.
// the closing beat passes the queue, then the state register, before the first result.
// beats past 64 entries are dropped and reported through overflowed.
// busy rises while the two-deep queue is full, which happens during emit.
// results cannot be held off; the receiver must take each one as it shows.
// reset clears the queue, the count and the state; stored keys are not reset.
module range_key_sorted_half_split (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] entry_lower,
	input  logic [63:0] entry_upper,
	input  logic        last_entry,
	output logic        result_valid,
	output logic [6:0]  entry_position,
	output logic        goes_right,
	output logic [63:0] left_lower,
	output logic [63:0] left_upper,
	output logic [63:0] right_lower,
	output logic [63:0] right_upper,
	output logic [5:0]  left_count,
	output logic [6:0]  right_count,
	output logic        overflowed,
	output logic        last_result
);
	import rks_pkg::*;
`include "range_key_sorted_half_split_assert.svh"

	logic   full, q_valid, q_pop, emitting, done;
	beat_t  q_beat;

	assign busy = full;

	rks_front u_front (
		.clk, .arst_n, .start, .entry_lower, .entry_upper, .last_entry,
		.full, .q_valid, .q_beat, .q_pop
	);

	rks_back u_back (
		.clk, .arst_n, .q_valid, .q_beat, .q_pop, .emitting, .done,
		.entry_position, .goes_right, .left_lower, .left_upper,
		.right_lower, .right_upper, .left_count, .right_count,
		.overflowed, .last_result
	);

	assign result_valid = emitting;

	`RKS_ASSERT_IMPL(a_no_pop_emit, emitting, !q_pop, "queue popped during emit")
	`RKS_ASSERT_IMPL(a_last_done, result_valid && last_result, done, "last result mismatch")
	`RKS_ASSERT_NEXT(a_done_idle, done, !emitting, "emit did not stop")
endmodule
